@@ hdl/csvfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants for the CSV field splitter: byte codes, result
// kinds and the result record passed between the parser and the output
// buffer.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // Results of one byte: count 0..2, first result in res0
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } decode_t;

endpackage
`default_nettype wire

@@ hdl/csvfs_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_parser
// Per-line quoting state and the byte decoder. Decodes the registered byte
// against the current state and commits the next state on advance.
// ----------------------------------------------------------------------------
module csvfs_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [7:0]       ch,
  input  wire logic             line_end,
  input  wire logic [7:0]       delim,
  output csvfs_pkg::decode_t    dec
);
  import csvfs_pkg::*;

  logic inside_quotes, quote_pending, field_nonempty, record_closed;
  logic inside_quotes_next, quote_pending_next, field_nonempty_next;
  logic record_closed_next;

  // Decode one byte into up to two results and the next state
  always_comb begin
    logic    consumed;
    logic    has_a;
    logic    has_b;
    result_t res_a;
    result_t res_end;

    inside_quotes_next  = inside_quotes;
    quote_pending_next  = quote_pending;
    field_nonempty_next = field_nonempty;
    record_closed_next  = record_closed;
    consumed = 1'b0;
    has_a    = 1'b0;
    has_b    = 1'b0;
    res_a    = '{kind: KIND_CHAR, ch: 8'd0, last: 1'b0};
    res_end  = '{kind: KIND_RECORD, ch: 8'd0, last: 1'b1};

    if (!record_closed) begin
      // Resolve a held quote first
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (ch == QUOTE_BYTE) begin
          has_a = 1'b1;
          res_a = '{kind: KIND_CHAR, ch: QUOTE_BYTE, last: 1'b0};
          field_nonempty_next = 1'b1;
          consumed = 1'b1;
        end else begin
          inside_quotes_next = 1'b0;
        end
      end
      if (!consumed) begin
        priority if (ch == NUL_BYTE) begin
          has_a = 1'b1;
          res_a = '{kind: KIND_RECORD, ch: 8'd0, last: 1'b0};
          record_closed_next = 1'b1;
        end else if (!inside_quotes_next && !field_nonempty_next && ch == QUOTE_BYTE) begin
          inside_quotes_next = 1'b1;
        end else if (inside_quotes_next && ch == QUOTE_BYTE) begin
          quote_pending_next = 1'b1;
        end else if (!inside_quotes_next && ch == delim) begin
          has_a = 1'b1;
          res_a = '{kind: KIND_FIELD, ch: 8'd0, last: 1'b0};
          field_nonempty_next = 1'b0;
        end else if (!inside_quotes_next && (ch == CR_BYTE || ch == LF_BYTE)) begin
          has_a = 1'b1;
          res_a = '{kind: KIND_RECORD, ch: 8'd0, last: 1'b0};
          record_closed_next = 1'b1;
        end else begin
          has_a = 1'b1;
          res_a = '{kind: KIND_CHAR, ch: ch, last: 1'b0};
          field_nonempty_next = 1'b1;
        end
      end
      // Close the record on the line's last byte
      if (line_end && !record_closed_next) begin
        has_b = 1'b1;
        record_closed_next = 1'b1;
      end
    end

    // Drop all line state after the last byte
    if (line_end) begin
      inside_quotes_next  = 1'b0;
      quote_pending_next  = 1'b0;
      field_nonempty_next = 1'b0;
      record_closed_next  = 1'b0;
    end

    // Pack results in order; mark the final one
    dec.cnt = {1'b0, has_a} + {1'b0, has_b};
    if (has_a) begin
      dec.res0      = res_a;
      dec.res0.last = !has_b;
      dec.res1      = res_end;
    end else begin
      dec.res0 = res_end;
      dec.res1 = res_end;
    end
  end

  // Commit line state when the byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes  <= 1'b0;
      quote_pending  <= 1'b0;
      field_nonempty <= 1'b0;
      record_closed  <= 1'b0;
    end else if (advance) begin
      inside_quotes  <= inside_quotes_next;
      quote_pending  <= quote_pending_next;
      field_nonempty <= field_nonempty_next;
      record_closed  <= record_closed_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/csvfs_result_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvfs_result_buf
// Two-entry result register. Loads all results of one byte at once and
// hands them out one transfer at a time, head first.
// ----------------------------------------------------------------------------
module csvfs_result_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  csvfs_pkg::decode_t     dec,
  input  wire logic              take,
  output logic [1:0]             cnt,
  output csvfs_pkg::result_t     head
);
  import csvfs_pkg::*;

  result_t slot0, slot1;

  assign head = slot0;

  // Load a new group, or shift up after a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= dec.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= dec.res0;
      slot1 <= dec.res1;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/csv_field_splitter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_splitter_unit
// Splits a line of delimited text into field characters, field ends and a
// record end, with quoted fields and doubled-quote escapes.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  in       | in_valid / in_stall  | char_in, line_end
//  out      | out_valid / out_stall| kind, char_out, run_last
//  cfg      | cfg_valid / cfg_ready| delimiter_char
//
// A byte is registered on transfer, decoded in the next cycle and its zero,
// one or two results loaded into the result register together. One byte
// per cycle while each gives at most one result and out_stall is low; after
// a byte with two results, the next byte that has results waits in the
// input register until one of them has left. Reset clears line state and
// sets the delimiter to a comma; output stall backs up into in_stall.
// ----------------------------------------------------------------------------
module csv_field_splitter_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      char_out,
  output logic            run_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] delimiter_char
);
  import csvfs_pkg::*;

  logic       item_valid;
  logic [7:0] item_ch;
  logic       item_end;
  logic [7:0] delim;
  logic       advance;
  logic       take;
  logic [1:0] buf_cnt;
  decode_t    dec;
  result_t    head;

  assign cfg_ready = 1'b1;

  // Hold the delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= DELIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delim <= delimiter_char;
    end
  end

  // Advance the byte when its results fit behind what leaves this cycle
  assign take    = out_valid && !out_stall;
  assign advance = item_valid &&
                   (dec.cnt == 2'd0 || buf_cnt == 2'd0 || (buf_cnt == 2'd1 && take));
  assign in_stall = item_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_ch  <= char_in;
      item_end <= line_end;
    end
  end

  csvfs_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .ch       (item_ch),
    .line_end (item_end),
    .delim    (delim),
    .dec      (dec)
  );

  csvfs_result_buf u_result_buf (
    .clk  (clk),
    .rst  (rst),
    .load (advance && dec.cnt != 2'd0),
    .dec  (dec),
    .take (take),
    .cnt  (buf_cnt),
    .head (head)
  );

  // Drive the output ports from the head entry
  assign out_valid = buf_cnt != 2'd0;
  assign kind      = head.kind;
  assign char_out  = head.ch;
  assign run_last  = head.last;

endmodule
`default_nettype wire

@@ tb/sv/csv_field_splitter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter_unit_tb
// Sends lines of delimited text through the field splitter, one byte per
// transfer. A scoreboard tracks the quoting state of each line and predicts
// the field characters, field ends and record ends. Every result transfer is
// checked in order. Both channels idle at random, the delimiter is
// rewritten between phases, and the result side once holds off long enough
// for the block to back up into its input.
// ----------------------------------------------------------------------------
import csvfs_pkg::*;

class csv_split_scoreboard;
  logic [7:0] delim;
  bit in_quotes;
  bit quote_held;
  bit field_open;
  bit record_done;
  int errors;
  result_t expected_results[$];

  function new();
    delim = DELIM_RESET;
    errors = 0;
    clear_line();
  endfunction

  function void clear_line();
    in_quotes = 1'b0;
    quote_held = 1'b0;
    field_open = 1'b0;
    record_done = 1'b0;
  endfunction

  function void add(kind_t k, logic [7:0] c);
    result_t r;
    r.kind = k;
    r.ch = c;
    r.last = 1'b0;
    expected_results = {expected_results, r};
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Advance the line state by one accepted byte and queue its results
  function void accept_byte(logic [7:0] c, logic le);
    int n_prior;
    bit taken;
    n_prior = expected_results.size();
    taken = 1'b0;
    if (!record_done) begin
      // Resolve a held quote first: a second quote is a literal one
      if (quote_held) begin
        quote_held = 1'b0;
        if (c == QUOTE_BYTE) begin
          add(KIND_CHAR, QUOTE_BYTE);
          field_open = 1'b1;
          taken = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!taken) begin
        if (c == NUL_BYTE) begin
          add(KIND_RECORD, 8'h00);
          record_done = 1'b1;
        end else if (!in_quotes && !field_open && c == QUOTE_BYTE) begin
          in_quotes = 1'b1;
        end else if (in_quotes && c == QUOTE_BYTE) begin
          quote_held = 1'b1;
        end else if (!in_quotes && c == delim) begin
          add(KIND_FIELD, 8'h00);
          field_open = 1'b0;
        end else if (!in_quotes && (c == CR_BYTE || c == LF_BYTE)) begin
          add(KIND_RECORD, 8'h00);
          record_done = 1'b1;
        end else begin
          add(KIND_CHAR, c);
          field_open = 1'b1;
        end
      end
      // Close the last field if the line ends without a record end
      if (le && !record_done) begin
        add(KIND_RECORD, 8'h00);
        record_done = 1'b1;
      end
    end
    if (le) begin
      clear_line();
    end
    if (expected_results.size() > n_prior) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endfunction

  // Compare one result transfer with the oldest prediction
  function void check_result(logic [1:0] k, logic [7:0] c, logic rl);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d char_out 0x%02h run_last %0b", k, c, rl);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (k !== 2'(want.kind)) begin
      $error("kind: expected %0d, actual %0d", want.kind, k);
      errors++;
    end
    if (c !== want.ch) begin
      $error("char_out: expected 0x%02h, actual 0x%02h", want.ch, c);
      errors++;
    end
    if (rl !== want.last) begin
      $error("run_last: expected %0b, actual %0b", want.last, rl);
      errors++;
    end
  endfunction
endclass

module csv_field_splitter_unit_tb;

  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 64;

  typedef struct packed {
    logic [7:0] c;
    logic       le;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       run_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] delimiter_char = DELIM_RESET;

  csv_split_scoreboard sb = new();
  line_byte_t line_q[$];
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  csv_field_splitter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_in        (char_in),
    .line_end       (line_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .char_out       (char_out),
    .run_last       (run_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .delimiter_char (delimiter_char)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Byte that stays inside an unquoted field
  function automatic logic [7:0] pick_plain(bit first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == sb.delim || c == CR_BYTE || c == LF_BYTE ||
               (first && c == QUOTE_BYTE));
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] c, input logic le);
    line_byte_t b;
    b.c = c;
    b.le = le;
    line_q = {line_q, b};
  endtask

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] c, input logic le);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    line_end <= le;
    do @(posedge clk); while (in_stall);
    sb.accept_byte(c, le);
  endtask

  task automatic send_line();
    foreach (line_q[i]) begin
      send_byte(line_q[i].c, line_q[i].le);
    end
  endtask

  // Quoted field with random content, doubled quotes and embedded specials
  task automatic push_quoted(input int len, input bit specials);
    logic [7:0] c;
    push_byte(QUOTE_BYTE, 1'b0);
    for (int i = 0; i < len; i++) begin
      case (specials ? $urandom_range(0, 7) : 7)
        0: push_byte(sb.delim, 1'b0);
        1: push_byte($urandom_range(0, 1) ? CR_BYTE : LF_BYTE, 1'b0);
        2: begin
          push_byte(QUOTE_BYTE, 1'b0);
          push_byte(QUOTE_BYTE, 1'b0);
        end
        default: begin
          c = 8'($urandom_range(1, 255));
          push_byte(c, 1'b0);
          if (c == QUOTE_BYTE) begin
            push_byte(QUOTE_BYTE, 1'b0);
          end
        end
      endcase
    end
    push_byte(QUOTE_BYTE, 1'b0);
  endtask

  // Well-formed line: fields joined by the delimiter, then an optional terminator
  task automatic build_formed_line();
    int n_fields;
    int len;
    line_q.delete();
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) begin
        push_byte(sb.delim, 1'b0);
      end
      len = $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          for (int i = 0; i < len; i++) begin
            push_byte(pick_plain(i == 0), 1'b0);
          end
        end
        2: push_quoted(len, 1'b0);
        default: push_quoted(len, 1'b1);
      endcase
    end
    case ($urandom_range(0, 4))
      0: ;
      1: push_byte(CR_BYTE, 1'b0);
      2: push_byte(LF_BYTE, 1'b0);
      3: begin
        push_byte(CR_BYTE, 1'b0);
        push_byte(LF_BYTE, 1'b0);
      end
      default: begin
        push_byte(LF_BYTE, 1'b0);
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    if (line_q.size() == 0) begin
      push_byte(pick_plain(1'b1), 1'b0);
    end
    line_q[line_q.size() - 1].le = 1'b1;
  endtask

  // Noise line: random bytes weighted toward the special codes
  task automatic build_noise_line();
    int len;
    line_q.delete();
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: push_byte(QUOTE_BYTE, i == len - 1);
          1: push_byte(sb.delim, i == len - 1);
          2: push_byte(CR_BYTE, i == len - 1);
          3: push_byte(LF_BYTE, i == len - 1);
          default: push_byte(NUL_BYTE, i == len - 1);
        endcase
      end else begin
        push_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
    end
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] v);
    cfg_valid <= 1'b1;
    delimiter_char <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.delim = v;
  endtask

  task automatic run_phase(input logic [7:0] v, input bit with_hold);
    int sent;
    drain();
    write_delimiter(v);
    calm = ($urandom_range(0, 3) == 0);
    sent = 0;
    // Hold off the result side while bytes keep coming back to back
    if (with_hold) begin
      calm = 1'b1;
      hold_req = 1'b1;
      repeat (4) begin
        build_formed_line();
        send_line();
        sent += line_q.size();
      end
      calm = 1'b0;
    end
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        build_noise_line();
      end else begin
        build_formed_line();
      end
      send_line();
      sent += line_q.size();
    end
  endtask

  // Result side: random stall per transfer, one long hold on request
  initial begin
    int k;
    forever begin
      if (hold_req) begin
        k = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        k = draw_gap();
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (rst || out_valid !== 1'b1);
      sb.check_result(kind, char_out, run_last);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] delim_plan [8];
    delim_plan = '{8'd59, 8'hFF, NUL_BYTE, QUOTE_BYTE, CR_BYTE, LF_BYTE, 8'h09,
                   DELIM_RESET};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Doubled quote, delimiter inside quotes, quote closed by delimiter,
    // record end then ignored bytes
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte("a", 1'b0);
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte(",", 1'b0);
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte(",", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CR_BYTE, 1'b0);
    send_byte("z", 1'b0);
    send_byte("q", 1'b1);
    // Line ends with a quote pending
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte("b", 1'b0);
    send_byte(QUOTE_BYTE, 1'b1);
    // NUL ends the record
    send_byte(NUL_BYTE, 1'b0);
    send_byte("a", 1'b1);
    // LF inside quotes, line ends with quotes open: two results
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte(LF_BYTE, 1'b0);
    send_byte("x", 1'b1);
    // Delimiter on the last byte: field end plus record end
    send_byte(",", 1'b1);
    // Quote in the middle of an unquoted field is a plain character
    send_byte(8'h01, 1'b0);
    send_byte(QUOTE_BYTE, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(LF_BYTE, 1'b1);

    foreach (delim_plan[i]) begin
      run_phase(delim_plan[i], i == 1);
    end
    run_phase(8'($urandom_range(0, 255)), 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/csvfs_pkg.sv
hdl/csvfs_parser.sv
hdl/csvfs_result_buf.sv
hdl/csv_field_splitter_unit.sv
tb/sv/csv_field_splitter_unit_tb.sv
